FILE: src/etpg_pkg.sv
// Package for the edge table pulse generator: sizes, operation and state
// codes, and the structs passed between the front queue, the back end and the top.
// Depends on nothing.
package etpg_pkg;

  localparam int MAX_EDGES   = 16;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = $clog2(MAX_EDGES);
  localparam int CNT_W       = $clog2(MAX_EDGES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_IDX_W   = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_REPEAT_PERIOD = 1'b0;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_TICK2,
    ST_FIND,
    ST_REARM,
    ST_SCAN,
    ST_ARM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] edge_time;
    logic              edge_level;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic edge_fired;
    logic table_full;
  } result_t;

endpackage

FILE: src/etpg_front.sv
// Front end: accepts input transactions, decodes the opcode and holds the items
// in a short queue for the back end.
// Depends on etpg_pkg.
module etpg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic [etpg_pkg::TIME_W-1:0] edge_time,
  input  logic                       edge_level,
  output logic                       item_valid,
  input  logic                       item_ready,
  output etpg_pkg::item_t            item
);

  localparam int PTR_W = (etpg_pkg::QUEUE_DEPTH > 1) ? $clog2(etpg_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(etpg_pkg::QUEUE_DEPTH + 1);

  etpg_pkg::item_t   mem [etpg_pkg::QUEUE_DEPTH];
  etpg_pkg::item_t   new_item;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready   = (fill != FILL_W'(etpg_pkg::QUEUE_DEPTH));
  assign item_valid = (fill != '0);
  assign item       = mem[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    new_item.op         = opcode ? etpg_pkg::OP_ADD : etpg_pkg::OP_TICK;
    new_item.edge_time  = edge_time;
    new_item.edge_level = edge_level;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(etpg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(etpg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

FILE: src/etpg_back.sv
// Back end: the edge table, the cycle and round counters and the sequencer
// that carries out tick and add items one at a time.
// Depends on etpg_pkg.
module etpg_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [etpg_pkg::DATA_W-1:0] repeat_period,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  etpg_pkg::item_t             item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output etpg_pkg::result_t           res
);

  localparam int TW = etpg_pkg::TIME_W;
  localparam int CW = etpg_pkg::CNT_W;
  localparam int IW = etpg_pkg::IDX_W;

  etpg_pkg::state_t state;
  etpg_pkg::state_t state_next;

  logic [TW-1:0] times [etpg_pkg::MAX_EDGES];
  logic          levels [etpg_pkg::MAX_EDGES];

  logic [CW-1:0] edge_count;
  logic [CW-1:0] edge_count_next;
  logic [CW-1:0] next_index;
  logic [CW-1:0] next_index_next;
  logic          armed;
  logic          armed_next;
  logic [TW-1:0] round_start;
  logic [TW-1:0] round_start_next;
  logic [TW-1:0] cycle_count;
  logic [TW-1:0] cycle_count_next;
  logic          pin_state;
  logic          pin_state_next;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_next;
  logic [TW-1:0] rel;
  logic [TW-1:0] rel_next;
  logic [TW-1:0] cmd_time;
  logic [TW-1:0] cmd_time_next;
  logic          cmd_level;
  logic          cmd_level_next;
  logic          fired;
  logic          fired_next;
  logic          full;
  logic          full_next;

  logic          tbl_insert;
  logic          tbl_set_level;
  logic [IW-1:0] zero_idx;
  logic [IW-1:0] rd_addr;
  logic [TW-1:0] rd_time;
  logic          rd_level;
  logic [TW-1:0] when_time;
  logic [TW-1:0] cyc_inc;
  logic          later_than;
  logic [CW-1:0] ni_inc;
  logic          ptr_in_range;

  assign zero_idx = (edge_count == CW'(1)) ? '0 : IW'(1);

  always_comb begin
    case (state)
      etpg_pkg::ST_TICK:  rd_addr = next_index[IW-1:0];
      etpg_pkg::ST_TICK2: rd_addr = next_index[IW-1:0];
      etpg_pkg::ST_REARM: rd_addr = zero_idx;
      default:            rd_addr = ptr[IW-1:0];
    endcase
  end

  assign rd_time      = times[rd_addr];
  assign rd_level     = levels[rd_addr];
  assign when_time    = round_start + rd_time;
  assign cyc_inc      = cycle_count + TW'(1);
  assign later_than   = (when_time > cycle_count);
  assign ni_inc       = next_index + CW'(1);
  assign ptr_in_range = (ptr < edge_count);

  assign res.pin_level  = pin_state;
  assign res.edge_fired = fired;
  assign res.table_full = full;

  always_comb begin
    state_next       = state;
    edge_count_next  = edge_count;
    next_index_next  = next_index;
    armed_next       = armed;
    round_start_next = round_start;
    cycle_count_next = cycle_count;
    pin_state_next   = pin_state;
    ptr_next         = ptr;
    rel_next         = rel;
    cmd_time_next    = cmd_time;
    cmd_level_next   = cmd_level;
    fired_next       = fired;
    full_next        = full;
    tbl_insert       = 1'b0;
    tbl_set_level    = 1'b0;
    item_ready       = 1'b0;
    res_valid        = 1'b0;

    case (state)
      etpg_pkg::ST_IDLE: begin
        item_ready = 1'b1;
      end
      etpg_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          item_ready = 1'b1;
          state_next = etpg_pkg::ST_IDLE;
        end
      end
      etpg_pkg::ST_TICK: begin
        cycle_count_next = cyc_inc;
        state_next       = etpg_pkg::ST_RESULT;
        if (armed && (next_index < edge_count) && (cyc_inc == when_time)) begin
          pin_state_next  = rd_level;
          next_index_next = ni_inc;
          fired_next      = 1'b1;
          if (!((ni_inc >= edge_count) && (repeat_period == '0))) begin
            state_next = etpg_pkg::ST_TICK2;
          end
        end
      end
      etpg_pkg::ST_TICK2: begin
        if ((repeat_period != '0) &&
            ((next_index >= edge_count) || (rd_time > repeat_period))) begin
          next_index_next  = '0;
          round_start_next = round_start + repeat_period;
        end
        armed_next = 1'b1;
        state_next = etpg_pkg::ST_RESULT;
      end
      etpg_pkg::ST_FIND: begin
        if (ptr_in_range && (rd_time < cmd_time)) begin
          ptr_next = ptr + CW'(1);
        end else if (ptr_in_range && (rd_time == cmd_time)) begin
          tbl_set_level = 1'b1;
          state_next    = etpg_pkg::ST_REARM;
        end else if (edge_count == CW'(etpg_pkg::MAX_EDGES)) begin
          full_next  = 1'b1;
          state_next = etpg_pkg::ST_RESULT;
        end else begin
          tbl_insert      = 1'b1;
          edge_count_next = edge_count + CW'(1);
          if (ptr <= next_index) begin
            next_index_next = ni_inc;
          end
          state_next = etpg_pkg::ST_REARM;
        end
      end
      etpg_pkg::ST_REARM: begin
        state_next = etpg_pkg::ST_RESULT;
        if (edge_count == '0) begin
          state_next = etpg_pkg::ST_RESULT;
        end else if (cycle_count == '0) begin
          if (next_index != CW'(1)) begin
            pin_state_next  = levels[0];
            armed_next      = later_than;
            next_index_next = (later_than || !armed) ? CW'(zero_idx) : edge_count;
          end
        end else begin
          rel_next   = cycle_count - round_start;
          ptr_next   = '0;
          state_next = etpg_pkg::ST_SCAN;
        end
      end
      etpg_pkg::ST_SCAN: begin
        if (ptr_in_range && (rd_time <= rel)) begin
          ptr_next = ptr + CW'(1);
        end else begin
          state_next = etpg_pkg::ST_ARM;
        end
      end
      etpg_pkg::ST_ARM: begin
        state_next = etpg_pkg::ST_RESULT;
        if (ptr == next_index) begin
          state_next = etpg_pkg::ST_RESULT;
        end else if (!ptr_in_range) begin
          if (armed) begin
            armed_next      = 1'b0;
            next_index_next = edge_count;
          end
        end else begin
          armed_next      = later_than;
          next_index_next = later_than ? ptr : (armed ? edge_count : next_index);
        end
      end
      default: begin
        state_next = etpg_pkg::ST_IDLE;
      end
    endcase

    if (item_ready && item_valid) begin
      cmd_time_next  = item.edge_time;
      cmd_level_next = item.edge_level;
      fired_next     = 1'b0;
      full_next      = 1'b0;
      ptr_next       = '0;
      state_next     = (item.op == etpg_pkg::OP_ADD) ? etpg_pkg::ST_FIND : etpg_pkg::ST_TICK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count  <= '0;
      next_index  <= '0;
      armed       <= 1'b0;
      round_start <= '0;
      cycle_count <= '0;
      pin_state   <= 1'b0;
    end else begin
      edge_count  <= edge_count_next;
      next_index  <= next_index_next;
      armed       <= armed_next;
      round_start <= round_start_next;
      cycle_count <= cycle_count_next;
      pin_state   <= pin_state_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    rel       <= rel_next;
    cmd_time  <= cmd_time_next;
    cmd_level <= cmd_level_next;
    fired     <= fired_next;
    full      <= full_next;
  end

  always_ff @(posedge clk) begin
    if (tbl_insert) begin
      for (int g = 1; g < etpg_pkg::MAX_EDGES; g++) begin
        if (CW'(g) > ptr) begin
          times[g]  <= times[g-1];
          levels[g] <= levels[g-1];
        end
      end
    end
    if (tbl_insert || tbl_set_level) begin
      times[ptr[IW-1:0]]  <= cmd_time;
      levels[ptr[IW-1:0]] <= cmd_level;
    end
  end

endmodule

FILE: src/edge_table_pulse_generator.sv
// Top level of the edge table pulse generator: configuration register port,
// front queue, back end and the output register.
// Depends on etpg_pkg, etpg_front and etpg_back.
//
//   Channel  Signals                                   Direction
//   in       in_valid/in_ready, opcode, edge_time,     into block
//            edge_level
//   out      out_valid/out_ready, pin_level,           out of block
//            edge_fired, table_full
//   cfg      psel, penable, pwrite, paddr, pwdata,     APB register port
//            prdata, pready
//
// A tick passes through the TICK and RESULT states of the back-end sequencer, and
// through TICK2 between them when an edge fires and the pattern goes on. An add
// steps FIND once per table entry before its position, then REARM (not when the
// table is full) and, when the cycle count is nonzero, SCAN once per entry at or
// before the round offset and ARM, before RESULT. Reset is synchronous and needs
// no clearing pass; the queue takes transactions while the back end is busy, and
// the back end stalls while the output register is full.
module edge_table_pulse_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [31:0]                   edge_time,
  input  logic                          edge_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          pin_level,
  output logic                          edge_fired,
  output logic                          table_full,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [etpg_pkg::DATA_W-1:0]   pwdata,
  output logic [etpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [etpg_pkg::DATA_W-1:0] repeat_period;
  logic                        reg_hit;
  etpg_pkg::item_t             item;
  logic                        item_valid;
  logic                        item_ready;
  etpg_pkg::result_t           res;
  etpg_pkg::result_t           out_res;
  logic                        res_valid;
  logic                        res_ready;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[etpg_pkg::ADDR_W-1:2] == etpg_pkg::REG_REPEAT_PERIOD);
  assign prdata  = reg_hit ? repeat_period : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_period <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      repeat_period <= pwdata;
    end
  end

  etpg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .edge_time  (edge_time),
    .edge_level (edge_level),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  etpg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .repeat_period (repeat_period),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign pin_level  = out_res.pin_level;
  assign edge_fired = out_res.edge_fired;
  assign table_full = out_res.table_full;

endmodule

FILE: bench/edge_table_pulse_generator_tb.sv
// Testbench for edge_table_pulse_generator: directed and random edge tables, ticks and
// repeat periods, every result compared field by field with a predictor of the pattern state.
// Depends on etpg_pkg and the edge_table_pulse_generator RTL.
`timescale 1ns / 100ps

module edge_table_pulse_generator_tb;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PRINTS = 100;
  localparam logic [etpg_pkg::REG_IDX_W-1:0] REG_SPARE = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = etpg_pkg::OP_TICK;
  logic [31:0] edge_time = '0;
  logic edge_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pin_level;
  logic edge_fired;
  logic table_full;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [etpg_pkg::ADDR_W-1:0] paddr = '0;
  logic [etpg_pkg::DATA_W-1:0] pwdata = '0;
  logic [etpg_pkg::DATA_W-1:0] prdata;
  logic pready;

  logic [etpg_pkg::TIME_W-1:0] tbl_time [etpg_pkg::MAX_EDGES];
  logic tbl_level [etpg_pkg::MAX_EDGES];
  int n_edges = 0;
  int ptr = 0;
  bit live = 1'b0;
  logic [etpg_pkg::TIME_W-1:0] round_base = '0;
  logic [etpg_pkg::TIME_W-1:0] now_cycle = '0;
  logic [etpg_pkg::TIME_W-1:0] period_q = '0;
  logic pin_q = 1'b0;

  etpg_pkg::result_t results_due [$];
  etpg_pkg::result_t want;
  int mismatches = 0;
  int results_seen = 0;
  int burst_left = 1;
  int holds_wanted = 0;
  int holds_done = 0;
  int hold_left = 0;
  int run_cycles = 0;
  logic [15:0] ready_tick = '0;

  edge_table_pulse_generator dut (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic void arm_edge(input logic [etpg_pkg::TIME_W-1:0] when, input int idx);
    if (live) begin
      live = 1'b0;
      ptr = n_edges;
    end
    if (when > now_cycle) begin
      live = 1'b1;
      ptr = idx;
    end
  endfunction

  function automatic void retarget_pointer();
    int k;
    logic [etpg_pkg::TIME_W-1:0] rel;
    if (n_edges == 0) return;
    if (now_cycle == 0) begin
      if (ptr == 1) return;
      pin_q = tbl_level[0];
      if (n_edges == 1) begin
        ptr = 0;
        arm_edge(round_base + tbl_time[0], 0);
      end else begin
        ptr = 1;
        arm_edge(round_base + tbl_time[1], 1);
      end
      return;
    end
    rel = now_cycle - round_base;
    k = 0;
    while (k < n_edges && tbl_time[k] <= rel) k++;
    if (k == ptr) return;
    if (k >= n_edges) begin
      if (live) begin
        live = 1'b0;
        ptr = n_edges;
      end
      return;
    end
    arm_edge(round_base + tbl_time[k], k);
  endfunction

  function automatic bit insert_edge(input logic [etpg_pkg::TIME_W-1:0] t, input logic lvl);
    int p;
    p = 0;
    while (p < n_edges && tbl_time[p] < t) p++;
    if (p < n_edges && tbl_time[p] == t) begin
      tbl_level[p] = lvl;
    end else begin
      if (n_edges >= etpg_pkg::MAX_EDGES) return 1'b1;
      for (int i = n_edges; i > p; i--) begin
        tbl_time[i] = tbl_time[i-1];
        tbl_level[i] = tbl_level[i-1];
      end
      tbl_time[p] = t;
      tbl_level[p] = lvl;
      n_edges++;
      if (p <= ptr) ptr++;
    end
    retarget_pointer();
    return 1'b0;
  endfunction

  function automatic bit advance_cycle();
    logic [etpg_pkg::TIME_W-1:0] target;
    now_cycle = now_cycle + 1'b1;
    if (!live || ptr >= n_edges) return 1'b0;
    target = round_base + tbl_time[ptr];
    if (now_cycle != target) return 1'b0;
    pin_q = tbl_level[ptr];
    ptr++;
    if (ptr >= n_edges && period_q == 0) return 1'b1;
    if (period_q != 0 && (ptr >= n_edges || tbl_time[ptr] > period_q)) begin
      ptr = 0;
      round_base = round_base + period_q;
    end
    live = 1'b1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
  endtask

  task automatic send_item(input etpg_pkg::op_t op, input logic [etpg_pkg::TIME_W-1:0] t,
                           input logic lvl);
    etpg_pkg::result_t due;
    in_valid <= 1'b1;
    opcode <= op;
    edge_time <= t;
    edge_level <= lvl;
    do @(posedge clk); while (!in_ready);
    due.edge_fired = 1'b0;
    due.table_full = 1'b0;
    if (op == etpg_pkg::OP_ADD) due.table_full = insert_edge(t, lvl);
    else due.edge_fired = advance_cycle();
    due.pin_level = pin_q;
    results_due.insert(results_due.size(), due);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
  endtask

  task automatic send_tick();
    send_item(etpg_pkg::OP_TICK, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic reg_write(input logic [etpg_pkg::REG_IDX_W-1:0] idx,
                           input logic [etpg_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == etpg_pkg::REG_REPEAT_PERIOD) period_q = data;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {etpg_pkg::REG_REPEAT_PERIOD, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== period_q)
      report_mismatch($sformatf("repeat_period reads %0h, holds %0h", prdata, period_q));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_cycle_zero();
    send_item(etpg_pkg::OP_ADD, 32'd3, 1'b1);
    send_item(etpg_pkg::OP_ADD, 32'd0, 1'b0);
    send_item(etpg_pkg::OP_ADD, 32'd5, 1'b0);
  endtask

  task automatic test_one_shot();
    repeat (6) send_tick();
  endtask

  task automatic test_period_restart();
    wait_drained();
    repeat (4) @(posedge clk);
    reg_write(REG_SPARE, '1);
    reg_write(etpg_pkg::REG_REPEAT_PERIOD, 32'd12);
    send_item(etpg_pkg::OP_ADD, 32'd9, 1'b1);
    repeat (3) send_tick();
    send_item(etpg_pkg::OP_ADD, 32'd7, 1'b0);
    repeat (3) send_tick();
    send_item(etpg_pkg::OP_ADD, 32'd2, 1'b1);
    send_item(etpg_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1);
    send_item(etpg_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
    repeat (3) send_tick();
  endtask

  task automatic test_random_pattern(input logic [etpg_pkg::DATA_W-1:0] period,
                                     input int count, input bit pause_midway);
    logic [etpg_pkg::TIME_W-1:0] t;
    int pick;
    wait_drained();
    repeat (4) @(posedge clk);
    reg_write(etpg_pkg::REG_REPEAT_PERIOD, period);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick >= 15) begin
        send_tick();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5 && n_edges != 0) t = tbl_time[$urandom_range(0, n_edges - 1)];
        else if (pick < 9 && period_q >= 2 && period_q <= 1000)
          t = $urandom_range(1, period_q - 1);
        else if (pick < 9) t = now_cycle - round_base + $urandom_range(1, 60);
        else t = $urandom;
        send_item(etpg_pkg::OP_ADD, t, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_output_backpressure();
    holds_wanted++;
    repeat (40) send_tick();
  endtask

  task automatic test_period_extremes();
    test_random_pattern(32'd1, 120, 1'b0);
    test_random_pattern(32'hFFFF_FFFF, 120, 1'b0);
    test_random_pattern(32'd0, 150, 1'b0);
  endtask

  always @(posedge clk) begin
    ready_tick <= ready_tick + 1'b1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_wanted) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      case (ready_tick[8:7])
        2'd0: begin
          out_ready <= 1'b1;
        end
        2'd1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2'd2: begin
          out_ready <= (ready_tick[2:0] != 3'd0);
        end
        default: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("transaction %0d arrived with no item pending", results_seen));
      end else begin
        want = results_due.pop_front();
        if (pin_level !== want.pin_level)
          report_mismatch($sformatf("transaction %0d pin_level %b, expected %b",
                                    results_seen, pin_level, want.pin_level));
        if (edge_fired !== want.edge_fired)
          report_mismatch($sformatf("transaction %0d edge_fired %b, expected %b",
                                    results_seen, edge_fired, want.edge_fired));
        if (table_full !== want.table_full)
          report_mismatch($sformatf("transaction %0d table_full %b, expected %b",
                                    results_seen, table_full, want.table_full));
      end
      results_seen++;
    end
  end

  initial begin
    while (run_cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      run_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_cycle_zero();
    test_one_shot();
    test_period_restart();
    test_random_pattern(32'd48, 700, 1'b0);
    test_output_backpressure();
    test_random_pattern(32'd96, 450, 1'b1);
    test_period_extremes();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/etpg_pkg.sv
src/etpg_front.sv
src/etpg_back.sv
src/edge_table_pulse_generator.sv
bench/edge_table_pulse_generator_tb.sv
